// File: hdl/atf_pkg.sv
// atf_pkg: shared constants and types of the averaged temperature fan thermostat.
// No dependencies; imported by the top level and its checker.

package atf_pkg;

  // Averaging window and derived widths
  localparam int WINDOW   = 10;
  localparam int SAMPLE_W = 10;
  localparam int IDX_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W    = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);

  // sum / WINDOW as (sum * RECIP) >> RECIP_SH, exact for every SUM_W-bit sum
  localparam int RECIP_SH    = SUM_W + $clog2(WINDOW);
  localparam int RECIP       = ((1 << RECIP_SH) + WINDOW - 1) / WINDOW;
  localparam int RECIP_W     = SUM_W + 1;
  localparam int MEAN_FULL_W = SUM_W + RECIP_W - RECIP_SH;

  // Field widths
  localparam int RAW_W   = 16;
  localparam int OFS_W   = 10;
  localparam int GAIN_W  = 16;
  localparam int TEMP_W  = 16;
  localparam int PROD_W  = 28;
  localparam int CFG_W   = 16;
  localparam int CIDX_W  = 3;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;

  // Register indexes
  localparam logic [CIDX_W-1:0] REG_COUNT_OFFSET = 3'd0;
  localparam logic [CIDX_W-1:0] REG_GAIN         = 3'd1;
  localparam logic [CIDX_W-1:0] REG_BIAS         = 3'd2;
  localparam logic [CIDX_W-1:0] REG_ON_THRESH    = 3'd3;
  localparam logic [CIDX_W-1:0] REG_OFF_THRESH   = 3'd4;

  // Register reset values
  localparam logic [OFS_W-1:0]         RST_COUNT_OFFSET = 10'd45;
  localparam logic [GAIN_W-1:0]        RST_GAIN         = 16'd3186;
  localparam logic signed [TEMP_W-1:0] RST_BIAS         = 16'sd384;
  localparam logic signed [TEMP_W-1:0] RST_ON_THRESH    = 16'sd7168;
  localparam logic signed [TEMP_W-1:0] RST_OFF_THRESH   = 16'sd6656;

  // Output word, mean in the low bits
  typedef struct packed {
    logic                     fan_on;
    logic signed [TEMP_W-1:0] temperature_q8;
    logic [SAMPLE_W-1:0]      mean_count;
  } out_word_t;

  localparam int OUT_PAD_W = OUT_TDATA_W - $bits(out_word_t);

endpackage

// File: hdl/averaged_temperature_fan_thermostat_top.sv
// averaged_temperature_fan_thermostat_top: moving-average thermostat with fan hysteresis.
// Depends on atf_pkg; sample ring kept in a local synchronous memory.
//
//  channel   dir  bits  handshake            content
//  s_axis    in   16    tvalid/tready        raw converter word
//  m_axis    out  32    tvalid/tready        mean, Q8.8 temperature, fan flag
//  cfg       in   16    cfg_we_i, no ready   register index + value
//
// One word accepted per cycle while s_axis_tready is high; each result passes the ring read,
// sum update, reciprocal multiply, scale multiply and threshold stage into the output queue.
// Up to six words may be outstanding; tready drops only when the output queue
// plus the pipeline would overflow. No clearing pass: reset clears the per-entry
// valid bits at once, and an entry that is not valid reads as zero.

module averaged_temperature_fan_thermostat_top
  import atf_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // s_axis_tdata: [15:0] raw_sample
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [IN_TDATA_W-1:0]    s_axis_tdata,
  // m_axis_tdata: [9:0] mean_count, [25:10] temperature_q8, [26] fan_on, [31:27] zero
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [OUT_TDATA_W-1:0]   m_axis_tdata,
  input  logic                     cfg_we_i,
  input  logic [CIDX_W-1:0]        cfg_idx_i,
  input  logic [CFG_W-1:0]         cfg_data_i
);

  localparam int OUT_DEPTH = 6;
  localparam int PTR_W     = $clog2(OUT_DEPTH);
  localparam int CNT_W     = $clog2(OUT_DEPTH + 1);
  localparam int SHR_W     = PROD_W - 8;
  localparam int TSUM_W    = SHR_W + 1;

  // ---------------- configuration registers ----------------
  logic [OFS_W-1:0]         offset_q;
  logic [GAIN_W-1:0]        gain_q;
  logic signed [TEMP_W-1:0] bias_q, on_q, off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= RST_COUNT_OFFSET;
      gain_q   <= RST_GAIN;
      bias_q   <= RST_BIAS;
      on_q     <= RST_ON_THRESH;
      off_q    <= RST_OFF_THRESH;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_COUNT_OFFSET: offset_q <= cfg_data_i[OFS_W-1:0];
        REG_GAIN:         gain_q   <= cfg_data_i;
        REG_BIAS:         bias_q   <= $signed(cfg_data_i);
        REG_ON_THRESH:    on_q     <= $signed(cfg_data_i);
        REG_OFF_THRESH:   off_q    <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic             in_acc, out_pop, push;
  logic [CNT_W-1:0] credit_q, credit_d;

  assign s_axis_tready = (credit_q < CNT_W'(OUT_DEPTH));
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    credit_d = credit_q;
    if (in_acc && !out_pop)      credit_d = credit_q + 1'b1;
    else if (!in_acc && out_pop) credit_d = credit_q - 1'b1;
  end

  // ---------------- stage 0: ring read ----------------
  logic [SAMPLE_W-1:0] ring_q [WINDOW];
  logic [WINDOW-1:0]   ring_vld_q;
  logic [IDX_W-1:0]    wr_idx_q;
  logic [SUM_W-1:0]    sum_q;

  logic                s1_vld_q, s1_ent_vld_q;
  logic [SAMPLE_W-1:0] s1_sample_q, s1_old_q;
  logic [IDX_W-1:0]    s1_idx_q;

  // Read of slot k+WINDOW always lands after the write of slot k, so no bypass.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_old_q    <= ring_q[wr_idx_q];
      s1_sample_q <= s_axis_tdata[SAMPLE_W-1:0];
      s1_idx_q    <= wr_idx_q;
    end
    if (s1_vld_q) begin
      ring_q[s1_idx_q] <= s1_sample_q;
    end
  end

  // ---------------- stage 1: running sum ----------------
  logic [SAMPLE_W-1:0] s1_old;
  logic [SUM_W-1:0]    sum_d;

  assign s1_old = s1_ent_vld_q ? s1_old_q : '0;
  assign sum_d  = sum_q - SUM_W'(s1_old) + SUM_W'(s1_sample_q);

  logic                s2_vld_q;
  logic [SUM_W-1:0]    s2_sum_q;

  // ---------------- stage 2: mean by reciprocal ----------------
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
  logic [SUM_W+RECIP_W-1:0] mean_prod;
  logic [MEAN_FULL_W-1:0]   mean_full;
  logic [SAMPLE_W-1:0]      mean_d;

  assign mean_prod = (SUM_W+RECIP_W)'(s2_sum_q) * (SUM_W+RECIP_W)'(RECIP_C);
  assign mean_full = mean_prod[SUM_W+RECIP_W-1:RECIP_SH];
  assign mean_d    = (mean_full > MEAN_FULL_W'((1 << SAMPLE_W) - 1)) ?
                     '1 : mean_full[SAMPLE_W-1:0];

  logic                s3_vld_q;
  logic [SAMPLE_W-1:0] s3_mean_q;

  // ---------------- stage 3: scale multiply ----------------
  logic signed [OFS_W:0]    diff;
  logic signed [PROD_W-1:0] prod_d;

  assign diff   = $signed({1'b0, s3_mean_q}) - $signed({1'b0, offset_q});
  assign prod_d = PROD_W'(diff) * PROD_W'($signed({1'b0, gain_q}));

  logic                     s4_vld_q;
  logic [SAMPLE_W-1:0]      s4_mean_q;
  logic signed [PROD_W-1:0] s4_prod_q;

  // ---------------- stage 4: bias, saturate, hysteresis ----------------
  logic signed [SHR_W-1:0]  shr;
  logic signed [TSUM_W-1:0] tsum;
  logic signed [TEMP_W-1:0] temp;
  logic                     fan_q, fan_d;

  assign shr  = s4_prod_q[PROD_W-1:8];   // arithmetic >>> 8, floors negatives
  assign tsum = TSUM_W'(shr) + TSUM_W'(bias_q);

  always_comb begin
    priority if (tsum > TSUM_W'(32767))       temp = 16'sh7fff;
    else if (tsum < -TSUM_W'(32768))          temp = 16'sh8000;
    else                                      temp = tsum[TEMP_W-1:0];
  end

  // on test first, off test second: crossed thresholds end off
  always_comb begin
    fan_d = fan_q;
    if (temp > on_q)  fan_d = 1'b1;
    if (temp < off_q) fan_d = 1'b0;
  end

  assign push = s4_vld_q;

  // ---------------- pipeline registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q   <= '0;
      wr_idx_q   <= '0;
      ring_vld_q <= '0;
      sum_q      <= '0;
      fan_q      <= 1'b0;
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      s3_vld_q   <= 1'b0;
      s4_vld_q   <= 1'b0;
    end else begin
      credit_q <= credit_d;
      s1_vld_q <= in_acc;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      if (in_acc) begin
        wr_idx_q <= (wr_idx_q == IDX_W'(WINDOW - 1)) ? '0 : wr_idx_q + 1'b1;
      end
      if (s1_vld_q) begin
        sum_q                <= sum_d;
        ring_vld_q[s1_idx_q] <= 1'b1;
      end
      if (s4_vld_q) begin
        fan_q <= fan_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc)   s1_ent_vld_q <= ring_vld_q[wr_idx_q];
    if (s1_vld_q) s2_sum_q     <= sum_d;
    if (s2_vld_q) s3_mean_q    <= mean_d;
    if (s3_vld_q) begin
      s4_mean_q <= s3_mean_q;
      s4_prod_q <= prod_d;
    end
  end

  // ---------------- output queue ----------------
  out_word_t        fifo_q [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  out_word_t        push_word, head;

  assign push_word.fan_on         = fan_d;
  assign push_word.temperature_q8 = temp;
  assign push_word.mean_count     = s4_mean_q;

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= push_word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (out_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !out_pop)      cnt_q <= cnt_q + 1'b1;
      else if (!push && out_pop) cnt_q <= cnt_q - 1'b1;
    end
  end

  assign head          = fifo_q[rd_ptr_q];
  assign m_axis_tvalid = (cnt_q != '0);
  assign out_pop       = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, head};

endmodule

// File: hdl/atf_checker.sv
// atf_checker: port-level assertions for the thermostat top, attached by bind.
// Depends on atf_pkg; sees only the top-level ports.

module atf_checker
  import atf_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   cfg_we_i,
  input logic [CIDX_W-1:0]      cfg_idx_i,
  input logic [CFG_W-1:0]       cfg_data_i
);

  logic signed [TEMP_W-1:0] on_q, off_q;
  logic [3:0]               outst_q;
  logic                     in_acc, out_acc, fan;
  logic signed [TEMP_W-1:0] temp;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign fan     = m_axis_tdata[SAMPLE_W+TEMP_W];
  assign temp    = $signed(m_axis_tdata[SAMPLE_W+TEMP_W-1:SAMPLE_W]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q    <= RST_ON_THRESH;
      off_q   <= RST_OFF_THRESH;
      outst_q <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == REG_ON_THRESH)  on_q  <= $signed(cfg_data_i);
      if (cfg_we_i && cfg_idx_i == REG_OFF_THRESH) off_q <= $signed(cfg_data_i);
      if (in_acc && !out_acc)      outst_q <= outst_q + 1'b1;
      else if (!in_acc && out_acc) outst_q <= outst_q - 1'b1;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> outst_q != 4'd0)
    else $error("result without an outstanding input word");

  a_fan_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && fan |-> !(temp < off_q))
    else $error("fan on below off threshold");

  a_fan_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !fan |-> !(temp > on_q) || (temp < off_q))
    else $error("fan off above on threshold");

endmodule

bind averaged_temperature_fan_thermostat_top atf_checker u_atf_checker (.*);

// File: dv/averaged_temperature_fan_thermostat_tb.sv
// Testbench for averaged_temperature_fan_thermostat_top: a directed part, then random phases.
// Needs atf_pkg and the top level only; the scoreboard class predicts and checks every word.
`timescale 1ns / 1ps

module testbench;
  import atf_pkg::*;

  localparam int          HALF_PERIOD  = 5;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          DRAIN_CYCLES = 12;    // pipeline depth plus margin
  localparam int          HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int          PHASE_ITEMS  = 256;
  localparam int          RAND_PHASES  = 5;
  localparam logic [CIDX_W-1:0] REG_UNUSED_LO = 3'd5;   // indexes above the last register
  localparam logic [CIDX_W-1:0] REG_UNUSED_HI = 3'd7;

  // Predicts each result word from the accepted samples and checks the output stream.
  class thermo_scoreboard;
    logic [SAMPLE_W-1:0]         ring [WINDOW];
    int unsigned                 slot;
    int unsigned                 sum;
    bit                          fan;
    logic [OFS_W-1:0]            offset;
    logic [GAIN_W-1:0]           gain;
    logic signed [TEMP_W-1:0]    bias;
    logic signed [TEMP_W-1:0]    on_th;
    logic signed [TEMP_W-1:0]    off_th;
    out_word_t                   expected_readings[$];
    int                          errors;

    function new();
      foreach (ring[k]) ring[k] = '0;
      slot   = 0;
      sum    = 0;
      fan    = 1'b0;
      offset = RST_COUNT_OFFSET;
      gain   = RST_GAIN;
      bias   = RST_BIAS;
      on_th  = RST_ON_THRESH;
      off_th = RST_OFF_THRESH;
      errors = 0;
    endfunction

    function void write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_COUNT_OFFSET: offset = val[OFS_W-1:0];
        REG_GAIN:         gain   = val;
        REG_BIAS:         bias   = val;
        REG_ON_THRESH:    on_th  = val;
        REG_OFF_THRESH:   off_th = val;
        default: ;        // unknown index: ignored
      endcase
    endfunction

    function void note_sample(logic [IN_TDATA_W-1:0] raw);
      logic [SAMPLE_W-1:0] sample;
      int unsigned         mean;
      longint              scaled;
      out_word_t           word;
      sample     = raw[SAMPLE_W-1:0];
      sum        = sum - ring[slot] + sample;
      ring[slot] = sample;
      slot       = (slot + 1 == WINDOW) ? 0 : slot + 1;
      mean       = sum / WINDOW;
      if (mean > 1023) mean = 1023;
      // floor of the product / 256, then bias, then saturate to 16 bits
      scaled = (longint'(mean) - longint'(offset)) * longint'(gain);
      scaled = (scaled >>> 8) + longint'(bias);
      if (scaled > 32767) scaled = 32767;
      if (scaled < -32768) scaled = -32768;
      // on test first, off test second: crossed thresholds leave the fan off
      if (scaled > longint'(on_th)) fan = 1'b1;
      if (scaled < longint'(off_th)) fan = 1'b0;
      word.mean_count     = mean[SAMPLE_W-1:0];
      word.temperature_q8 = scaled[TEMP_W-1:0];
      word.fan_on         = fan;
      expected_readings.push_back(word);
    endfunction

    function void check_word(logic [OUT_TDATA_W-1:0] data);
      out_word_t got;
      out_word_t want;
      got = data[$bits(out_word_t)-1:0];
      if (expected_readings.size() == 0) begin
        $display("%0t unexpected word: expected none actual %h", $time, data);
        errors++;
        return;
      end
      want = expected_readings.pop_front();
      if (got.mean_count !== want.mean_count) begin
        $display("%0t mean_count: expected %0d actual %0d", $time,
                 want.mean_count, got.mean_count);
        errors++;
      end
      if (got.temperature_q8 !== want.temperature_q8) begin
        $display("%0t temperature_q8: expected %0d actual %0d", $time,
                 want.temperature_q8, got.temperature_q8);
        errors++;
      end
      if (got.fan_on !== want.fan_on) begin
        $display("%0t fan_on: expected %0b actual %0b", $time, want.fan_on, got.fan_on);
        errors++;
      end
      if (data[OUT_TDATA_W-1:$bits(out_word_t)] !== '0) begin
        $display("%0t pad bits: expected 0 actual %h", $time,
                 data[OUT_TDATA_W-1:$bits(out_word_t)]);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i = 1'b0;
  logic [CIDX_W-1:0]      cfg_idx_i = '0;
  logic [CFG_W-1:0]       cfg_data_i = '0;

  thermo_scoreboard sb = new();
  int               cycle_count = 0;
  int               burst_left = 0;
  int               hold_requests = 0;
  int               walk_level = 512;

  averaged_temperature_fan_thermostat_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Both handshakes are sampled at the edge, before any update of this step.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_sample(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
    end
  end

  // Receiver: stall pattern of its own, plus a long hold-off on request.
  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    int unsigned period;
    int          served;
    served = 0;
    @(posedge rst_ni);
    forever begin
      if (served < hold_requests) begin
        // sender keeps offering words, so the block fills and drops s_axis_tready
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        served++;
      end
      mode   = $urandom_range(3, 0);
      span   = $urandom_range(120, 10);
      period = $urandom_range(6, 1);
      for (int c = 0; c < span; c++) begin
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= $urandom_range(1, 0);
          2:       m_axis_tready <= ($urandom_range(3, 0) == 0);
          default: m_axis_tready <= ((c / period) % 2 == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // One sample word; bursts of random length separated by random gaps, none when dense.
  task automatic send_sample(input logic [IN_TDATA_W-1:0] raw, input bit dense);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = dense ? 0 : (($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1));
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(24, 1);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= raw;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
  endtask

  // Lowers valid, waits out every expected word and the pipeline tail.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.expected_readings.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Block is idle here, so the model takes the value at once.
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  task automatic end_writes();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all(input logic [CFG_W-1:0] ofs, input logic [CFG_W-1:0] gn,
                           input logic [CFG_W-1:0] bs, input logic [CFG_W-1:0] on_v,
                           input logic [CFG_W-1:0] off_v);
    write_reg(REG_COUNT_OFFSET, ofs);
    write_reg(REG_GAIN, gn);
    write_reg(REG_BIAS, bs);
    write_reg(REG_ON_THRESH, on_v);
    write_reg(REG_OFF_THRESH, off_v);
    if ($urandom_range(1, 0))
      write_reg(CIDX_W'($urandom_range(REG_UNUSED_HI, REG_UNUSED_LO)), CFG_W'($urandom));
    end_writes();
  endtask

  // Mix of extremes and values that keep the temperature in a useful range.
  task automatic random_config();
    logic [CFG_W-1:0] ofs;
    logic [CFG_W-1:0] gn;
    logic [CFG_W-1:0] bs;
    logic [CFG_W-1:0] on_v;
    logic [CFG_W-1:0] off_v;
    ofs = CFG_W'($urandom);   // upper bits random, only the low ten count
    case ($urandom_range(3, 0))
      0: ofs[OFS_W-1:0] = '0;
      1: ofs[OFS_W-1:0] = '1;
      2: ofs[OFS_W-1:0] = OFS_W'($urandom_range(100, 0));
      default: ;
    endcase
    case ($urandom_range(5, 0))
      0:       gn = '0;
      1:       gn = '1;
      default: gn = CFG_W'($urandom_range(8000, 1000));
    endcase
    case ($urandom_range(5, 0))
      0:       bs = 16'h8000;
      1:       bs = 16'h7FFF;
      default: bs = CFG_W'(int'($urandom_range(4000, 0)) - 2000);
    endcase
    if ($urandom_range(3, 0) == 0) begin
      on_v  = CFG_W'($urandom);
      off_v = CFG_W'($urandom);
    end else begin
      on_v  = CFG_W'($urandom_range(12000, 0));
      off_v = on_v - CFG_W'($urandom_range(1500, 0));
    end
    write_all(ofs, gn, bs, on_v, off_v);
  endtask

  // Mostly a slow random walk so the mean drifts across the thresholds.
  function automatic logic [IN_TDATA_W-1:0] next_sample();
    logic [IN_TDATA_W-1:0] raw;
    raw = IN_TDATA_W'($urandom);
    if ($urandom_range(9, 0) < 7) begin
      walk_level = walk_level + int'($urandom_range(80, 0)) - 40;
      if (walk_level < 0) walk_level = 0;
      if (walk_level > 1023) walk_level = 1023;
      raw[SAMPLE_W-1:0] = SAMPLE_W'(walk_level);
    end
    return raw;
  endfunction

  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Start-up with reset registers: zeroed entries pull the early means down,
    // upper input bits are ignored, then a full window of 1023.
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFC00, 1'b0);
    repeat (10) send_sample(16'h03FF, 1'b0);
    drain();

    // Large negative product saturates low
    write_all(16'h03FF, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000);
    repeat (4) send_sample(16'h0000, 1'b0);
    drain();

    // Saturates high at the off threshold: only the on test holds, fan ends on
    write_all(16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF);
    write_reg(REG_UNUSED_LO, 16'hFFFF);
    end_writes();
    repeat (4) send_sample(16'hFFFF, 1'b0);
    drain();

    // Small negative product: the shift rounds toward minus infinity
    write_all(16'h03FF, 16'h0001, 16'h0000, 16'h0000, 16'hFFFF);
    repeat (3) send_sample(16'h03FE, 1'b0);
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == 0)
        write_all(RST_COUNT_OFFSET, RST_GAIN, RST_BIAS, RST_ON_THRESH, RST_OFF_THRESH);
      else
        random_config();
      if (p % 2 == 1) hold_requests++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(15, 0) == 0)
          send_sample(($urandom_range(1, 0) ? 16'hFFFF : 16'h0000), p == 2);
        else
          send_sample(next_sample(), p == 2);
      end
      drain();
    end

    if (sb.errors == 0 && sb.expected_readings.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/atf_pkg.sv
hdl/averaged_temperature_fan_thermostat_top.sv
hdl/atf_checker.sv
dv/averaged_temperature_fan_thermostat_tb.sv
